@@ rtl/core/signed_varint_codec_defines.svh @@
// Assertion macros for the signed varint codec.
`ifndef SIGNED_VARINT_CODEC_DEFINES_SVH
`define SIGNED_VARINT_CODEC_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SVC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define SVC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/svc_pkg.sv @@
// Shared types, codes and helper functions for the signed varint codec.
package svc_pkg;

  localparam int VALUE_W         = 64;
  localparam int GROUP_W         = 7;
  localparam int MAX_GROUPS_WIDE = 9;
  localparam int MAX_GROUPS_NARR = 5;
  localparam int END_BIT         = 7;
  localparam int SIGN_BIT        = 6;

  typedef logic [3:0] grp_idx_t;

  localparam logic OP_ENCODE  = 1'b0;
  localparam logic OP_DECODE  = 1'b1;
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_VALUE = 1'b1;

  typedef struct packed {
    logic                 done;
    logic [VALUE_W-1:0]   value;
  } dec_res_t;

  function automatic logic [VALUE_W-1:0] sext32(logic [VALUE_W-1:0] x);
    return {{(VALUE_W-32){x[31]}}, x[31:0]};
  endfunction

  // 7-bit group idx of v, group 0 being the least significant.
  function automatic logic [GROUP_W-1:0] group_at(logic [VALUE_W-1:0] v, grp_idx_t idx);
    logic [GROUP_W-1:0] r;
    r = '0;
    for (int i = 0; i < MAX_GROUPS_WIDE; i++) begin
      if (idx == grp_idx_t'(i)) begin
        r = v[GROUP_W*i +: GROUP_W];
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/core/svc_sizer.sv @@
// Group count for an encode item: index of its most significant group.
module svc_sizer (
  input  logic [63:0]        value,
  input  logic               wide,
  output svc_pkg::grp_idx_t  nm1
);
  import svc_pkg::*;

  grp_idx_t           cap;
  logic [VALUE_W-1:0] t;

  always_comb begin
    cap = wide ? grp_idx_t'(MAX_GROUPS_WIDE - 1) : grp_idx_t'(MAX_GROUPS_NARR - 1);
    nm1 = cap;
    t   = '0;
    // walk down so the smallest fitting count wins
    for (int n = MAX_GROUPS_WIDE - 1; n >= 1; n--) begin
      t = $signed(value) >>> (GROUP_W * n - 1);
      if (((&t) || (~|t)) && (grp_idx_t'(n) <= cap)) begin
        nm1 = grp_idx_t'(n - 1);
      end
    end
  end

endmodule

@@ rtl/core/svc_dec.sv @@
// Decode accumulator: shifts in one stream byte per step.
module svc_dec (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         byte_in,
  input  logic               wide,
  output svc_pkg::dec_res_t  res
);
  import svc_pkg::*;

  logic [VALUE_W-1:0] acc;
  logic [VALUE_W-1:0] acc_next;
  logic [VALUE_W-1:0] base;
  logic               in_number;

  always_comb begin
    // first byte of a number presets the sign fill
    base      = in_number ? acc : {VALUE_W{byte_in[SIGN_BIT]}};
    acc_next  = {base[VALUE_W-GROUP_W-1:0], byte_in[GROUP_W-1:0]};
    res.done  = byte_in[END_BIT];
    res.value = wide ? acc_next : sext32(acc_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      in_number <= 1'b0;
    end else if (step) begin
      acc       <= acc_next;
      in_number <= !byte_in[END_BIT];
    end
  end

endmodule

@@ rtl/core/signed_varint_codec.sv @@
// Signed varint codec top level: item register, encode emitter, result register.
// An accepted item waits in the item register; its first result is then written to the result register.
// Throughput: decode takes one byte per cycle while the output is not stalled; encode
// holds the input until its last byte is emitted, one per group, paced by the result register.
// Reset (rst, synchronous): clears valids, decode state; wide_mode returns to 1.
module signed_varint_codec (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic signed [63:0] value_in,
  input  logic [7:0]         byte_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               kind,
  output logic [7:0]         byte_out,
  output logic signed [63:0] value_out,
  output logic               last
);
  import svc_pkg::*;

  `include "signed_varint_codec_defines.svh"

  logic               wide_mode;

  logic               item_valid;
  logic               item_op;
  logic [VALUE_W-1:0] item_value;
  logic [7:0]         item_byte;
  grp_idx_t           item_nm1;

  logic               enc_busy;
  grp_idx_t           enc_idx;

  logic [VALUE_W-1:0] value_ext;
  grp_idx_t           nm1_in;
  grp_idx_t           cur_idx;
  logic               advance;
  logic               work;
  logic               consume;
  logic               dec_step;
  logic               enc_last;
  dec_res_t           dec_res;

  assign value_ext = wide_mode ? VALUE_W'(value_in) : sext32(VALUE_W'(value_in));

  svc_sizer u_sizer (
    .value (value_ext),
    .wide  (wide_mode),
    .nm1   (nm1_in)
  );

  svc_dec u_dec (
    .clk     (clk),
    .rst     (rst),
    .step    (dec_step),
    .byte_in (item_byte),
    .wide    (wide_mode),
    .res     (dec_res)
  );

  always_comb begin
    advance  = !out_valid || !out_stall;
    work     = item_valid && advance;
    cur_idx  = enc_busy ? enc_idx : item_nm1;
    enc_last = (cur_idx == '0);
    dec_step = work && (item_op == OP_DECODE);
    consume  = work && ((item_op == OP_DECODE) || enc_last);
    in_stall = item_valid && !consume;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_mode <= 1'b1;
    end else if (cfg_we) begin
      wide_mode <= cfg_data;
    end
  end

  // item register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || consume) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_op    <= op;
      item_value <= value_ext;
      item_byte  <= byte_in;
      item_nm1   <= nm1_in;
    end
  end

  // encode emitter: counts groups down to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      enc_busy <= 1'b0;
      enc_idx  <= '0;
    end else if (work && (item_op == OP_ENCODE)) begin
      enc_busy <= !enc_last;
      enc_idx  <= cur_idx - grp_idx_t'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid && ((item_op == OP_ENCODE) || dec_res.done);
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      if (item_op == OP_ENCODE) begin
        kind      <= KIND_BYTE;
        byte_out  <= {enc_last, group_at(item_value, cur_idx)};
        value_out <= '0;
        last      <= enc_last;
      end else begin
        kind      <= KIND_VALUE;
        byte_out  <= '0;
        value_out <= dec_res.value;
        last      <= 1'b1;
      end
    end
  end

  `SVC_ASSERT_NOW(a_byte_flag_is_last, out_valid && (kind == KIND_BYTE), byte_out[END_BIT] == last, "end flag and last disagree")
  `SVC_ASSERT_NOW(a_value_is_single, out_valid && (kind == KIND_VALUE), last && (byte_out == '0), "decoded value result malformed")
  `SVC_ASSERT_NOW(a_busy_has_encode, enc_busy, item_valid && (item_op == OP_ENCODE), "emitter busy without encode item")
  `SVC_ASSERT_NEXT(a_encode_emits, work && (item_op == OP_ENCODE), out_valid && (kind == KIND_BYTE), "encode step gave no byte")

endmodule

@@ tb/tb_signed_varint_codec.sv @@
// Self-checking testbench for the signed varint codec: encode and decode items, both modes.
module tb_signed_varint_codec;
  timeunit 1ns;
  timeprecision 1ps;

  import svc_pkg::*;

  localparam logic MODE_NARROW = 1'b0;
  localparam logic MODE_WIDE   = 1'b1;
  localparam logic [7:0] END_FLAG   = 8'h80;
  localparam logic [7:0] SIGN_GROUP = 8'h40;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD     = 120;

  typedef struct packed {
    logic        kind;
    logic [7:0]  byte_v;
    logic [63:0] value;
    logic        last;
  } codec_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic               cfg_data = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               op = OP_ENCODE;
  logic signed [63:0] value_in = '0;
  logic [7:0]         byte_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               kind;
  logic [7:0]         byte_out;
  logic signed [63:0] value_out;
  logic               last;

  // predictor state
  logic          model_wide;
  logic [63:0]   acc;
  logic          mid_number;
  codec_result_t results_due[$];

  int errors = 0;
  bit quiet = 1'b0;
  int holds_asked = 0;
  int holds_served = 0;
  int stall_left = 0;

  signed_varint_codec dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .value_in  (value_in),
    .byte_in   (byte_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .byte_out  (byte_out),
    .value_out (value_out),
    .last      (last)
  );

  always #6 clk = ~clk;

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int pick_gap(int idle_pct);
    if (quiet || $urandom_range(0, 99) >= idle_pct) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  // wide spread of magnitudes, both signs, all bits random at some point
  function automatic logic [63:0] rand_value();
    logic [63:0] x;
    x = {$urandom, $urandom};
    return $signed(x) >>> $urandom_range(0, 63);
  endfunction

  function automatic void push_result(logic k, logic [7:0] b, logic [63:0] v, logic l);
    codec_result_t r;
    r.kind = k;
    r.byte_v = b;
    r.value = v;
    r.last = l;
    results_due.push_back(r);
  endfunction

  function automatic logic [63:0] narrow_value(logic [63:0] x);
    return {{32{x[31]}}, x[31:0]};
  endfunction

  function automatic void predict_encode(logic [63:0] raw);
    logic [63:0] v;
    logic [63:0] t;
    int n;
    int maxn;
    bit growing;
    v = model_wide ? raw : narrow_value(raw);
    maxn = model_wide ? 9 : 5;
    n = 1;
    growing = 1'b1;
    // smallest group count whose sign bit covers the value
    while (n < maxn && growing) begin
      t = $signed(v) >>> (7 * n - 1);
      if (t == '0 || t == '1) growing = 1'b0;
      else n++;
    end
    for (int i = n - 1; i > 0; i--) begin
      t = $signed(v) >>> (7 * i);
      push_result(KIND_BYTE, {1'b0, t[6:0]}, '0, 1'b0);
    end
    push_result(KIND_BYTE, END_FLAG | {1'b0, v[6:0]}, '0, 1'b1);
  endfunction

  function automatic void predict_decode(logic [7:0] b);
    if (!mid_number) acc = (b & SIGN_GROUP) != 0 ? '1 : '0;
    acc = {acc[56:0], b[6:0]};
    if ((b & END_FLAG) != 0) begin
      mid_number = 1'b0;
      push_result(KIND_VALUE, 8'h00, model_wide ? acc : narrow_value(acc), 1'b1);
    end else begin
      mid_number = 1'b1;
    end
  endfunction

  // result check first, then prediction for the item taken at this edge
  always @(posedge clk) begin
    codec_result_t exp_r;
    if (rst) begin
      model_wide = MODE_WIDE;
      acc = '0;
      mid_number = 1'b0;
      results_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result kind=%0d byte=%02h value=%016h last=%0d",
                   $time, kind, byte_out, value_out, last);
        end else begin
          exp_r = results_due.pop_front();
          if (kind !== exp_r.kind || byte_out !== exp_r.byte_v ||
              value_out !== exp_r.value || last !== exp_r.last) begin
            errors++;
            $display("%0t: mismatch expected kind=%0d byte=%02h value=%016h last=%0d",
                     $time, exp_r.kind, exp_r.byte_v, exp_r.value, exp_r.last);
            $display("%0t:          actual   kind=%0d byte=%02h value=%016h last=%0d",
                     $time, kind, byte_out, value_out, last);
          end
        end
      end
      if (cfg_we) model_wide = cfg_data;
      if (in_valid && !in_stall) begin
        if (op == OP_ENCODE) predict_encode(value_in);
        else predict_decode(byte_in);
      end
    end
  end

  // receiver pacing: random stalls, plus long holds on request
  always @(posedge clk) begin
    if (holds_served != holds_asked) begin
      holds_served++;
      stall_left = LONG_HOLD;
    end else if (stall_left == 0) begin
      stall_left = pick_gap(30);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_item(logic o, logic [63:0] v, logic [7:0] b);
    int gap;
    in_valid <= 1'b1;
    op <= o;
    value_in <= v;
    byte_in <= b;
    do @(posedge clk); while (in_stall);
    gap = pick_gap(45);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic encode(logic [63:0] v);
    send_item(OP_ENCODE, v, 8'($urandom));
  endtask

  task automatic decode(logic [7:0] b);
    send_item(OP_DECODE, {$urandom, $urandom}, b);
  endtask

  // wait for all results, then let any in-flight work settle
  task automatic drain();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    cfg_we <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_encode_extremes();
    drain();
    write_mode(MODE_WIDE);
    encode(64'd0);
    encode(-64'sd1);
    encode(64'd63);
    encode(-64'sd64);
    encode(64'd64);
    encode(64'h3fff_ffff_ffff_ffff);
    encode(64'hc000_0000_0000_0000);
    // top bit lost in nine groups
    encode(64'h7fff_ffff_ffff_ffff);
    encode(64'h8000_0000_0000_0000);
  endtask

  task automatic test_decode_basic();
    decode(8'hbf);
    decode(8'h40);
    decode(8'h80);
  endtask

  task automatic test_narrow_mode();
    drain();
    write_mode(MODE_NARROW);
    encode(64'hdead_beef_7fff_ffff);
    encode(64'h0000_0000_8000_0000);
    encode(-64'sd1);
    // over-long stream wraps
    decode(8'h3f);
    decode(8'h55);
    decode(8'h2a);
    decode(8'h7f);
    decode(8'h01);
    decode(8'hff);
  endtask

  task automatic test_mode_change_mid_number();
    decode(8'h08);
    encode(64'd100);
    drain();
    write_mode(MODE_WIDE);
    decode(8'h00);
    decode(8'h00);
    decode(8'h00);
    decode(8'h80);
  endtask

  task automatic test_backpressure();
    drain();
    quiet = 1'b1;
    holds_asked++;
    for (int k = 0; k < 16; k++) encode({1'b1, 63'($urandom)} ^ {$urandom, $urandom});
    drain();
    quiet = 1'b0;
  endtask

  task automatic test_random_phase(logic wide, int n_items);
    int count;
    int len;
    int sel;
    logic [7:0] b;
    drain();
    write_mode(wide);
    count = 0;
    while (count < n_items) begin
      quiet = (count < n_items / 3);
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        encode(rand_value());
        count++;
      end else if (sel < 90) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 12)
                                          : $urandom_range(1, wide ? 9 : 5);
        for (int k = 0; k < len; k++) begin
          b = 8'($urandom);
          b[7] = (k == len - 1);
          decode(b);
          count++;
        end
      end else begin
        decode(8'($urandom));
        count++;
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_encode_extremes();
    test_decode_basic();
    test_narrow_mode();
    test_mode_change_mid_number();
    test_backpressure();
    test_random_phase(MODE_WIDE, 65);
    test_random_phase(MODE_NARROW, 60);
    test_random_phase(MODE_WIDE, 55);
    drain();
    if (errors == 0 && results_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
